// File: rtl/nkrl_pkg.sv
// Package for the nearest key row lookup block: table sizes, controller states
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package nkrl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int ROW_W       = 32;
    localparam int QUERY_W     = 64;
    localparam int S_DATA_W    = 96;
    localparam int M_DATA_W    = 40;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_Q_FIRST,
        ST_Q_LAST,
        ST_SRCH_ISSUE,
        ST_SRCH_CMP,
        ST_L_CHECK,
        ST_L_INSERT,
        ST_SH_TEST,
        ST_SH_WRITE,
        ST_Q_HI,
        ST_Q_LO,
        ST_Q_EMPTY,
        ST_Q_OUT
    } nkrl_state_t;

    typedef enum logic [2:0] {
        RD_FIRST,
        RD_LAST,
        RD_MID,
        RD_POS,
        RD_POS_M1,
        RD_SHIFT
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    search_upd;
        logic    save_res;
        logic    shift_init;
        logic    shift_dec;
        logic    wr_shift;
        logic    wr_new;
        logic    set_ovf;
        logic    res_load;
        logic    res_empty;
    } nkrl_cmd_t;

    typedef struct packed {
        logic mode_query;
        logic count_zero;
        logic full;
        logic search_done;
        logic pos_lt_count;
        logic shift_done;
        logic key_lt;
        logic tgt_lt;
        logic key_eq;
        logic hi_nearer;
        logic out_free;
    } nkrl_status_t;

endpackage

`default_nettype wire

// File: rtl/nkrl_datapath.sv
// Datapath of the nearest key row lookup: key/row memory, search bounds,
// shift pointer, counters, comparators and the output register.
// Depends on nkrl_pkg.
`default_nettype none

module nkrl_datapath
    import nkrl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire nkrl_cmd_t           cmd,
    output nkrl_status_t             status,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    logic [KEY_W+ROW_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W+ROW_W-1:0] rdata_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_W+ROW_W-1:0] wr_data;
    logic                   wr_en;

    logic [CNT_W-1:0]       count_reg;
    logic [ROW_W-1:0]       next_row_reg;
    logic                   ovf_reg;
    logic                   mode_reg;
    logic [QUERY_W-1:0]     target_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic [CNT_W-1:0]       hi_reg;
    logic [CNT_W-1:0]       mid_reg;
    logic [CNT_W-1:0]       sh_reg;
    logic [KEY_W-1:0]       res_key_reg;
    logic [ROW_W-1:0]       res_row_reg;

    logic                   m_valid_reg;
    logic                   m_rvalid_reg;
    logic [ROW_W-1:0]       m_row_reg;
    logic                   m_ovf_reg;

    logic [CNT_W:0]         mid_sum;
    logic [CNT_W-1:0]       mid_next;
    logic [CNT_W-1:0]       last_idx;
    logic [CNT_W-1:0]       pos_m1;
    logic [CNT_W-1:0]       sh_m1;
    logic [KEY_W-1:0]       rd_key;
    logic [ROW_W-1:0]       rd_row;
    logic [KEY_W-1:0]       tgt_low;
    logic [KEY_W-1:0]       hi_dist;
    logic [KEY_W-1:0]       lo_dist;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next = mid_sum[CNT_W:1];
    assign last_idx = count_reg - CNT_W'(1);
    assign pos_m1   = lo_reg - CNT_W'(1);
    assign sh_m1    = sh_reg - CNT_W'(1);
    assign rd_key   = rdata_reg[KEY_W+ROW_W-1:ROW_W];
    assign rd_row   = rdata_reg[ROW_W-1:0];
    assign tgt_low  = target_reg[KEY_W-1:0];
    assign hi_dist  = res_key_reg - tgt_low;
    assign lo_dist  = tgt_low - rd_key;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FIRST:  rd_addr = '0;
            RD_LAST:   rd_addr = last_idx[IDX_W-1:0];
            RD_MID:    rd_addr = mid_next[IDX_W-1:0];
            RD_POS:    rd_addr = lo_reg[IDX_W-1:0];
            RD_POS_M1: rd_addr = pos_m1[IDX_W-1:0];
            RD_SHIFT:  rd_addr = sh_m1[IDX_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        wr_en   = cmd.wr_shift | cmd.wr_new;
        wr_addr = cmd.wr_shift ? sh_reg[IDX_W-1:0] : lo_reg[IDX_W-1:0];
        wr_data = cmd.wr_shift ? rdata_reg : {tgt_low, row_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= s_tuser;
            target_reg <= s_tuser ? s_tdata[S_DATA_W-1:KEY_W]
                                  : {{(QUERY_W-KEY_W){1'b0}}, s_tdata[KEY_W-1:0]};
            row_reg    <= next_row_reg;
            lo_reg     <= '0;
            hi_reg     <= count_reg;
        end
        else if (cmd.search_upd)
        begin
            if (status.key_lt)
            begin
                lo_reg <= mid_reg + CNT_W'(1);
            end
            else
            begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.rd_en && cmd.rd_sel == RD_MID)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.shift_init)
        begin
            sh_reg <= count_reg;
        end
        else if (cmd.shift_dec)
        begin
            sh_reg <= sh_m1;
        end
        if (cmd.save_res)
        begin
            res_key_reg <= rd_key;
            res_row_reg <= rd_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            next_row_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.capture && !s_tuser && next_row_reg != ROW_MAX)
            begin
                next_row_reg <= next_row_reg + ROW_W'(1);
            end
            if (cmd.wr_new)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            m_rvalid_reg <= !cmd.res_empty;
            m_row_reg    <= cmd.res_empty ? '0 : res_row_reg;
            m_ovf_reg    <= ovf_reg;
        end
    end

    always_comb
    begin
        status.mode_query   = mode_reg;
        status.count_zero   = (count_reg == '0);
        status.full         = (count_reg >= CNT_W'(TABLE_DEPTH));
        status.search_done  = (lo_reg >= hi_reg);
        status.pos_lt_count = (lo_reg < count_reg);
        status.shift_done   = (sh_reg == lo_reg);
        status.key_lt       = $signed({{(QUERY_W-KEY_W){1'b0}}, rd_key}) < $signed(target_reg);
        status.tgt_lt       = $signed(target_reg) < $signed({{(QUERY_W-KEY_W){1'b0}}, rd_key});
        status.key_eq       = ({{(QUERY_W-KEY_W){1'b0}}, rd_key} == target_reg);
        status.hi_nearer    = (hi_dist < lo_dist);
        status.out_free     = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-ROW_W-2){1'b0}}, m_ovf_reg, m_row_reg, m_rvalid_reg};

endmodule

`default_nettype wire

// File: rtl/nkrl_ctrl.sv
// Controller of the nearest key row lookup: sequences the searches, the
// insert shift and the result hand-off. Depends on nkrl_pkg.
`default_nettype none

module nkrl_ctrl
    import nkrl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire nkrl_status_t status,
    output nkrl_cmd_t         cmd
);

    nkrl_state_t state_reg;
    nkrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!status.mode_query)
                begin
                    state_next = ST_SRCH_ISSUE;
                end
                else if (status.count_zero)
                begin
                    state_next = ST_Q_EMPTY;
                end
                else
                begin
                    state_next = ST_Q_FIRST;
                end
            end
            ST_Q_FIRST:
            begin
                state_next = status.key_lt ? ST_Q_LAST : ST_Q_OUT;
            end
            ST_Q_LAST:
            begin
                state_next = status.tgt_lt ? ST_SRCH_ISSUE : ST_Q_OUT;
            end
            ST_SRCH_ISSUE:
            begin
                if (!status.search_done)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (status.mode_query)
                begin
                    state_next = ST_Q_HI;
                end
                else if (status.pos_lt_count)
                begin
                    state_next = ST_L_CHECK;
                end
                else
                begin
                    state_next = ST_L_INSERT;
                end
            end
            ST_SRCH_CMP:
            begin
                state_next = ST_SRCH_ISSUE;
            end
            ST_L_CHECK:
            begin
                state_next = status.key_eq ? ST_IDLE : ST_L_INSERT;
            end
            ST_L_INSERT:
            begin
                state_next = status.full ? ST_IDLE : ST_SH_TEST;
            end
            ST_SH_TEST:
            begin
                state_next = status.shift_done ? ST_IDLE : ST_SH_WRITE;
            end
            ST_SH_WRITE:
            begin
                state_next = ST_SH_TEST;
            end
            ST_Q_HI:
            begin
                state_next = status.key_eq ? ST_Q_OUT : ST_Q_LO;
            end
            ST_Q_LO:
            begin
                state_next = ST_Q_OUT;
            end
            ST_Q_EMPTY, ST_Q_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DISPATCH:
            begin
                cmd.rd_en  = status.mode_query && !status.count_zero;
                cmd.rd_sel = RD_FIRST;
            end
            ST_Q_FIRST:
            begin
                cmd.save_res = !status.key_lt;
                cmd.rd_en    = status.key_lt;
                cmd.rd_sel   = RD_LAST;
            end
            ST_Q_LAST:
            begin
                cmd.save_res = !status.tgt_lt;
            end
            ST_SRCH_ISSUE:
            begin
                if (!status.search_done)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                end
                else
                begin
                    cmd.rd_en  = status.mode_query || status.pos_lt_count;
                    cmd.rd_sel = RD_POS;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.search_upd = 1'b1;
            end
            ST_L_INSERT:
            begin
                cmd.set_ovf    = status.full;
                cmd.shift_init = !status.full;
            end
            ST_SH_TEST:
            begin
                cmd.wr_new = status.shift_done;
                cmd.rd_en  = !status.shift_done;
                cmd.rd_sel = RD_SHIFT;
            end
            ST_SH_WRITE:
            begin
                cmd.wr_shift  = 1'b1;
                cmd.shift_dec = 1'b1;
            end
            ST_Q_HI:
            begin
                cmd.save_res = 1'b1;
                cmd.rd_en    = !status.key_eq;
                cmd.rd_sel   = RD_POS_M1;
            end
            ST_Q_LO:
            begin
                cmd.save_res = !status.hi_nearer;
            end
            ST_Q_EMPTY:
            begin
                cmd.res_load  = status.out_free;
                cmd.res_empty = 1'b1;
            end
            ST_Q_OUT:
            begin
                cmd.res_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/nearest_key_row_lookup.sv
// Top level of the nearest key row lookup: joins controller and datapath.
// Depends on nkrl_pkg, nkrl_ctrl and nkrl_datapath.
//
// The block takes one item at a time. A load (tuser low) runs a binary search
// for its slot, then a duplicate check when the found slot already holds an
// entry, then the insert decision, then a read and a write for each table entry
// that moves up to open the slot, and last the write of the new entry; the single
// read port of the key/row memory sets both the search and the shift pace. A
// query (tuser high) checks the first and last entry, runs the same binary search
// and then picks the nearer of the two neighbouring entries; it ends early when it
// falls at or outside the stored range or the table is empty. Its result waits in
// an output register while the next item is taken; a query holds in its last state
// while that register still holds an untaken result. The memory contents are
// undefined after reset; only entries below the fill count are read, so no
// clearing pass runs.
`default_nettype none

module nearest_key_row_lookup
    import nkrl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // Fields from bit 0 up: load_value[31:0], query_value[95:32].
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // Fields from bit 0 up: mode.
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // Fields from bit 0 up: result_valid[0], nearest_row[32:1],
    // table_overflow[33], zero fill[39:34].
    output logic [M_DATA_W-1:0]      m_tdata
);

    nkrl_cmd_t    cmd;
    nkrl_status_t status;

    nkrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nkrl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input transfer accepted while an item was still in work.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == '0))
        else $error("Empty-table result carries a nonzero row.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_new && status.full))
        else $error("New entry written into a full table.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && (cmd.wr_new || cmd.wr_shift)))
        else $error("Table read and write requested in the same cycle.");
`endif

endmodule

`default_nettype wire

// File: tb/nearest_key_row_lookup_test.sv
// Self-checking testbench for nearest_key_row_lookup: drives loads and queries
// over the input stream and checks every result against a local predictor.
// Depends on nkrl_pkg and the nearest_key_row_lookup RTL.
`timescale 1ns / 1ps

module nearest_key_row_lookup_test;
    import nkrl_pkg::*;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic             overflow;
    } lookup_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
    logic [ROW_W-1:0] table_rows [TABLE_DEPTH];
    int               table_fill;
    logic [ROW_W-1:0] row_counter;
    logic             overflow_seen;
    lookup_result_t   pending_lookups [$];

    int mismatches;
    bit tx_idle;
    bit rx_idle;
    int rx_hold;

    nearest_key_row_lookup dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("nearest_key_row_lookup_test: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void record_load(input logic [KEY_W-1:0] value);
        int               pos;
        logic [ROW_W-1:0] row;
        row = row_counter;
        if (row_counter != ROW_MAX)
            row_counter++;
        pos = 0;
        while (pos < table_fill && table_keys[pos] < value)
            pos++;
        if (pos < table_fill && table_keys[pos] == value)
            return;
        if (table_fill >= TABLE_DEPTH)
        begin
            overflow_seen = 1'b1;
            return;
        end
        for (int i = table_fill; i > pos; i--)
        begin
            table_keys[i] = table_keys[i-1];
            table_rows[i] = table_rows[i-1];
        end
        table_keys[pos] = value;
        table_rows[pos] = row;
        table_fill++;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [QUERY_W-1:0] raw);
        lookup_result_t res;
        longint         target;
        longint         dist_hi;
        longint         dist_lo;
        int             lo;
        int             hi;
        int             mid;
        target       = $signed(raw);
        res.valid    = 1'b0;
        res.row      = '0;
        res.overflow = overflow_seen;
        if (table_fill == 0)
            return res;
        res.valid = 1'b1;
        lo = 0;
        hi = table_fill;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (longint'(table_keys[mid]) < target)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo == 0)
            res.row = table_rows[0];
        else if (lo == table_fill)
            res.row = table_rows[table_fill-1];
        else if (longint'(table_keys[lo]) == target)
            res.row = table_rows[lo];
        else
        begin
            dist_hi = longint'(table_keys[lo]) - target;
            dist_lo = target - longint'(table_keys[lo-1]);
            res.row = (dist_hi < dist_lo) ? table_rows[lo] : table_rows[lo-1];
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] random_load_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 300);
        if (r < 55 && table_fill > 0)
            return table_keys[$urandom_range(0, table_fill - 1)];
        if (r < 85 || table_fill == 0)
            return $urandom();
        return table_keys[$urandom_range(0, table_fill - 1)] + $urandom_range(0, 4) - 2;
    endfunction

    function automatic logic [QUERY_W-1:0] random_query_value();
        int     r;
        int     i;
        longint a;
        longint b;
        r = $urandom_range(0, 99);
        if (table_fill > 1 && r < 50)
        begin
            i = $urandom_range(0, table_fill - 2);
            a = longint'(table_keys[i]);
            b = longint'(table_keys[i+1]);
            if (r < 20)
                return a;
            if (r < 40)
                return a + (b - a) / 2 + longint'($urandom_range(0, 1));
            return a + longint'($urandom_range(0, 6)) - 3;
        end
        if (r < 70)
            return {$urandom(), $urandom()};
        if (r < 85)
            return -longint'($urandom_range(1, 1000));
        return {32'($urandom_range(0, 3)), $urandom()};
    endfunction

    task automatic send_item(input logic mode, input logic [KEY_W-1:0] load_value,
                             input logic [QUERY_W-1:0] query_value);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {query_value, load_value};
        do
            @(posedge clk);
        while (!s_tready);
        if (mode == MODE_QUERY)
            pending_lookups.push_back(predict_lookup(query_value));
        else
            record_load(load_value);
    endtask

    task automatic send_load(input logic [KEY_W-1:0] value);
        send_item(MODE_LOAD, value, {$urandom(), $urandom()});
    endtask

    task automatic send_query(input logic [QUERY_W-1:0] value);
        send_item(MODE_QUERY, $urandom(), value);
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 1) == 0)
            send_load(random_load_value());
        else
            send_query(random_query_value());
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] data);
        lookup_result_t want;
        if (pending_lookups.size() == 0)
        begin
            $error("result transfer with no query pending: %h", data);
            mismatches++;
            return;
        end
        want = pending_lookups.pop_front();
        if (data[0] !== want.valid)
        begin
            $error("result_valid expected %h actual %h", want.valid, data[0]);
            mismatches++;
        end
        if (data[32:1] !== want.row)
        begin
            $error("nearest_row expected %h actual %h", want.row, data[32:1]);
            mismatches++;
        end
        if (data[33] !== want.overflow)
        begin
            $error("table_overflow expected %h actual %h", want.overflow, data[33]);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
    end

    initial
    begin : result_sink
        int stall;
        int hold;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                hold    = rx_hold;
                rx_hold = 0;
                stall   = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else if (rx_idle && stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    task automatic test_empty_table();
        send_query(64'h8000_0000_0000_0000);
        send_query(64'h7FFF_FFFF_FFFF_FFFF);
        send_query(64'h0);
    endtask

    task automatic test_directed_lookups();
        send_load(32'd100);
        send_query(64'd5);
        send_load(32'hFFFF_FFFF);
        send_load(32'd0);
        send_load(32'd100);
        send_load(32'd200);
        send_load(32'h8000_0000);
        send_query(64'd150);
        send_query(64'd151);
        send_query(64'd149);
        send_query(64'd100);
        send_query(64'h8000_0000_0000_0000);
        send_query(64'h7FFF_FFFF_FFFF_FFFF);
        send_query(64'hFFFF_FFFF_FFFF_FFFF);
        send_query(64'h0000_0000_FFFF_FFFF);
        send_query(64'h0000_0001_0000_0000);
        send_query(64'h0000_0000_4000_0064);
        send_query(64'h0000_0000_BFFF_FFFF);
        send_query(64'h0000_0000_C000_0000);
    endtask

    // The sink refuses results for a long stretch while queries keep coming,
    // so the output register fills and the input side must stall.
    task automatic test_full_input_stall();
        tx_idle = 1'b0;
        rx_hold = 400;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 2)
                send_load(random_load_value());
            else
                send_query(random_query_value());
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            send_random_item();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Ascending keys above almost every stored one keep the insert shifts short.
    task automatic test_table_overflow();
        logic [KEY_W-1:0] value;
        value = 32'hE000_0000;
        while (table_fill < TABLE_DEPTH)
        begin
            send_load(value);
            value = value + 7;
        end
        send_query(64'h8000_0000_0000_0000);
        send_query(64'h7FFF_FFFF_FFFF_FFFF);
        send_load(table_keys[0]);
        send_query(random_query_value());
        for (int i = 0; i < 4; i++)
        begin
            send_load(value);
            value = value + 7;
            send_query(random_query_value());
        end
        test_random_mix(50);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_DEPTH + 64) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_LOAD;
        m_tready      = 1'b0;
        table_fill    = 0;
        row_counter   = '0;
        overflow_seen = 1'b0;
        mismatches    = 0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold       = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed_lookups();
        test_full_input_stall();
        test_random_mix(300);
        test_table_overflow();
        wait_for_drain();
        if (mismatches == 0)
            $display("nearest_key_row_lookup_test: PASS");
        else
            $display("nearest_key_row_lookup_test: FAIL");
        $finish;
    end

endmodule
